// ===== hdl/hnmb_pkg.sv =====
package hnmb_pkg;

   // Ring geometry and component format (signed Q2.14 in COMP_W bits).
   localparam int HIST_DEPTH = 128;
   localparam int COMP_W     = 16;
   localparam int IDX_W      = $clog2(HIST_DEPTH);
   localparam int CNT_W      = IDX_W + 1;
   localparam int ENTRY_W    = 3 * COMP_W;
   localparam int DIST_W     = COMP_W + 2;

   // Blend: round((4a + b) / 5) = floor((8a + 2b + 5) / 10). A bias of 5 * 2^COMP_W
   // keeps the dividend positive; the quotient then carries an offset of 2^(COMP_W-1).
   localparam int     SUM_W       = COMP_W + 4;
   localparam int     PROD_W      = 2 * SUM_W;
   localparam int     RECIP_SHIFT = SUM_W + 3;
   localparam longint RECIP_MUL   = ((longint'(1) << RECIP_SHIFT) + 9) / 10;
   localparam longint BLEND_BIAS  = 5 * (longint'(1) << COMP_W);
   localparam longint QUOT_OFFSET = longint'(1) << (COMP_W - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_BLEND,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      COMP_ENERGY,
      COMP_RISK,
      COMP_REWARD
   } comp_type;

   typedef struct packed {
      logic                     vld;
      comp_type                 comp;
      logic signed [COMP_W-1:0] cur;
      logic signed [COMP_W-1:0] hist;
   } blend_op_type;

   typedef struct packed {
      logic                     vld;
      comp_type                 comp;
      logic signed [COMP_W-1:0] value;
   } blend_res_type;

endpackage

// ===== hdl/hnmb_req_if.sv =====
interface hnmb_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [hnmb_pkg::COMP_W-1:0] energy_in;
   logic signed [hnmb_pkg::COMP_W-1:0] risk_in;
   logic signed [hnmb_pkg::COMP_W-1:0] reward_in;

   modport source (output valid, output energy_in, output risk_in, output reward_in,
                   input ready);
   modport sink (input valid, input energy_in, input risk_in, input reward_in,
                 output ready);
endinterface

// ===== hdl/hnmb_rsp_if.sv =====
interface hnmb_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [hnmb_pkg::COMP_W-1:0] energy_out;
   logic signed [hnmb_pkg::COMP_W-1:0] risk_out;
   logic signed [hnmb_pkg::COMP_W-1:0] reward_out;
   logic        [hnmb_pkg::IDX_W-1:0]  match_index;

   modport source (output valid, output energy_out, output risk_out, output reward_out,
                   output match_index, input ready);
   modport sink (input valid, input energy_out, input risk_out, input reward_out,
                 input match_index, output ready);
endinterface

// ===== hdl/hnmb_ram.sv =====
module hnmb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/hnmb_blend.sv =====
module hnmb_blend (
   input  logic                    clock,
   input  logic                    reset,
   input  hnmb_pkg::blend_op_type  op,
   output hnmb_pkg::blend_res_type res
);

   logic signed [hnmb_pkg::SUM_W:0]    cur_x;
   logic signed [hnmb_pkg::SUM_W:0]    hist_x;
   logic        [hnmb_pkg::SUM_W:0]    dividend_wide;
   logic        [hnmb_pkg::SUM_W-1:0]  dividend;
   logic        [hnmb_pkg::PROD_W-1:0] prod_in;
   logic        [hnmb_pkg::PROD_W-1:0] prod_ff;
   logic                               vld_ff;
   hnmb_pkg::comp_type                 comp_ff;
   logic        [hnmb_pkg::COMP_W-1:0] quot;

   // Biased dividend 8a + 2b + 5 + 5*2^W, always positive and below 2^SUM_W.
   assign cur_x  = (hnmb_pkg::SUM_W+1)'(op.cur);
   assign hist_x = (hnmb_pkg::SUM_W+1)'(op.hist);
   assign dividend_wide = (cur_x <<< 3) + (hist_x <<< 1) + (hnmb_pkg::SUM_W+1)'(5)
                        + (hnmb_pkg::SUM_W+1)'(hnmb_pkg::BLEND_BIAS);
   assign dividend = dividend_wide[hnmb_pkg::SUM_W-1:0];

   // Divide by ten through the reciprocal; exact for every dividend below 2^SUM_W.
   assign prod_in = hnmb_pkg::PROD_W'(dividend)
                  * hnmb_pkg::PROD_W'(hnmb_pkg::RECIP_MUL[hnmb_pkg::SUM_W-1:0]);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      comp_ff <= op.comp;
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= op.vld;
      end
   end

   assign quot      = prod_ff[hnmb_pkg::RECIP_SHIFT +: hnmb_pkg::COMP_W];
   assign res.vld   = vld_ff;
   assign res.comp  = comp_ff;
   assign res.value = quot - hnmb_pkg::COMP_W'(hnmb_pkg::QUOT_OFFSET);

endmodule

// ===== hdl/history_nearest_match_blend.sv =====
// Channel   Direction  Payload                                          Handshake
// req_chan  in         energy_in, risk_in, reward_in (signed Q2.14)     valid/ready
// rsp_chan  out        energy_out, risk_out, reward_out, match_index    valid/ready
//
// Each word is worked through in full before the next is accepted: the full scan of the
// history RAM through its single read port, one entry per cycle, then the read and distance
// pipeline, the blend of the three components, the load of the output register and a return
// to idle. Reset is synchronous and takes effect at once: a fill count marks every slot as
// zero, so no clearing pass is needed. A word is accepted only while the sequencer is idle;
// a finished result waits in the output register, and a stalled result holds the sequencer
// in its finish state before the next result is loaded.
module history_nearest_match_blend (
   input logic         clock,
   input logic         reset,
   hnmb_req_if.sink    req_chan,
   hnmb_rsp_if.source  rsp_chan
);

   hnmb_pkg::state_type state_ff, state_in;

   // Input word under work, packed as {energy, risk, reward}.
   logic [hnmb_pkg::ENTRY_W-1:0] x_ff;

   // Ring bookkeeping. The fill count saturates at the depth; slots at or above it read as zero.
   logic [hnmb_pkg::IDX_W-1:0] wp_ff;
   logic [hnmb_pkg::CNT_W-1:0] fill_ff;

   // Scan pipeline: read issue, distance, compare.
   logic [hnmb_pkg::CNT_W-1:0]   rd_cnt_ff;
   logic                         rd_issue;
   logic                         rd_vld_ff;
   logic [hnmb_pkg::IDX_W-1:0]   rd_idx_ff;
   logic [hnmb_pkg::ENTRY_W-1:0] ram_q;
   logic [hnmb_pkg::ENTRY_W-1:0] entry;
   logic [hnmb_pkg::DIST_W-1:0]  dist_in;
   logic                         d_vld_ff;
   logic [hnmb_pkg::IDX_W-1:0]   d_idx_ff;
   logic [hnmb_pkg::DIST_W-1:0]  dist_ff;
   logic [hnmb_pkg::ENTRY_W-1:0] d_vec_ff;
   logic [hnmb_pkg::DIST_W-1:0]  best_dist_ff;
   logic [hnmb_pkg::ENTRY_W-1:0] best_vec_ff;
   logic [hnmb_pkg::IDX_W-1:0]   best_idx_ff;
   logic                         scan_done;

   // Blend sequencing, one component per cycle through a shared multiplier.
   logic [1:0]                   bl_cnt_ff;
   hnmb_pkg::blend_op_type       bl_op;
   hnmb_pkg::blend_res_type      bl_res;
   hnmb_pkg::comp_type           bl_comp;
   logic signed [hnmb_pkg::COMP_W-1:0] res_energy_ff;
   logic signed [hnmb_pkg::COMP_W-1:0] res_risk_ff;
   logic signed [hnmb_pkg::COMP_W-1:0] res_reward_ff;

   logic accept;
   logic wr_en;
   logic load_rsp;

   // Output register.
   logic                               rsp_vld_ff;
   logic signed [hnmb_pkg::COMP_W-1:0] rsp_energy_ff;
   logic signed [hnmb_pkg::COMP_W-1:0] rsp_risk_ff;
   logic signed [hnmb_pkg::COMP_W-1:0] rsp_reward_ff;
   logic        [hnmb_pkg::IDX_W-1:0]  rsp_idx_ff;

   function automatic logic [hnmb_pkg::COMP_W-1:0] abs_diff(
      input logic signed [hnmb_pkg::COMP_W-1:0] a,
      input logic signed [hnmb_pkg::COMP_W-1:0] b
   );
      logic signed [hnmb_pkg::COMP_W:0] d;
      d = (hnmb_pkg::COMP_W+1)'(a) - (hnmb_pkg::COMP_W+1)'(b);
      if (d[hnmb_pkg::COMP_W]) begin
         d = -d;
      end
      return d[hnmb_pkg::COMP_W-1:0];
   endfunction

   hnmb_ram #(
      .WIDTH (hnmb_pkg::ENTRY_W),
      .DEPTH (hnmb_pkg::HIST_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (x_ff),
      .rd_en   (rd_issue),
      .rd_addr (rd_cnt_ff[hnmb_pkg::IDX_W-1:0]),
      .rd_data (ram_q)
   );

   hnmb_blend u_blend (
      .clock (clock),
      .reset (reset),
      .op    (bl_op),
      .res   (bl_res)
   );

   // Slots that were never written since reset hold the zero vector.
   assign entry = (hnmb_pkg::CNT_W'(rd_idx_ff) < fill_ff) ? ram_q : '0;

   assign dist_in =
        hnmb_pkg::DIST_W'(abs_diff(entry[3*hnmb_pkg::COMP_W-1 -: hnmb_pkg::COMP_W],
                                   x_ff[3*hnmb_pkg::COMP_W-1 -: hnmb_pkg::COMP_W]))
      + hnmb_pkg::DIST_W'(abs_diff(entry[2*hnmb_pkg::COMP_W-1 -: hnmb_pkg::COMP_W],
                                   x_ff[2*hnmb_pkg::COMP_W-1 -: hnmb_pkg::COMP_W]))
      + hnmb_pkg::DIST_W'(abs_diff(entry[hnmb_pkg::COMP_W-1 -: hnmb_pkg::COMP_W],
                                   x_ff[hnmb_pkg::COMP_W-1 -: hnmb_pkg::COMP_W]));

   assign scan_done = d_vld_ff && (d_idx_ff == hnmb_pkg::IDX_W'(hnmb_pkg::HIST_DEPTH - 1));

   assign bl_comp = hnmb_pkg::comp_type'(bl_cnt_ff);

   // Sequencer: next state and control strobes.
   always_comb begin
      state_in = state_ff;
      accept   = 1'b0;
      rd_issue = 1'b0;
      wr_en    = 1'b0;
      load_rsp = 1'b0;
      bl_op    = '0;
      unique case (state_ff)
         hnmb_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               accept   = 1'b1;
               state_in = hnmb_pkg::ST_SCAN;
            end
         end
         hnmb_pkg::ST_SCAN: begin
            rd_issue = (rd_cnt_ff < hnmb_pkg::CNT_W'(hnmb_pkg::HIST_DEPTH));
            if (scan_done) begin
               state_in = hnmb_pkg::ST_BLEND;
            end
         end
         hnmb_pkg::ST_BLEND: begin
            // The search is complete, so the input goes into the ring now.
            wr_en = (bl_cnt_ff == 2'd0);
            if (bl_cnt_ff != 2'd3) begin
               bl_op.vld  = 1'b1;
               bl_op.comp = bl_comp;
               case (bl_comp)
                  hnmb_pkg::COMP_ENERGY: begin
                     bl_op.cur  = x_ff[3*hnmb_pkg::COMP_W-1 -: hnmb_pkg::COMP_W];
                     bl_op.hist = best_vec_ff[3*hnmb_pkg::COMP_W-1 -: hnmb_pkg::COMP_W];
                  end
                  hnmb_pkg::COMP_RISK: begin
                     bl_op.cur  = x_ff[2*hnmb_pkg::COMP_W-1 -: hnmb_pkg::COMP_W];
                     bl_op.hist = best_vec_ff[2*hnmb_pkg::COMP_W-1 -: hnmb_pkg::COMP_W];
                  end
                  default: begin
                     bl_op.cur  = x_ff[hnmb_pkg::COMP_W-1 -: hnmb_pkg::COMP_W];
                     bl_op.hist = best_vec_ff[hnmb_pkg::COMP_W-1 -: hnmb_pkg::COMP_W];
                  end
               endcase
            end else begin
               // The last component result is captured at this edge.
               state_in = hnmb_pkg::ST_FINISH;
            end
         end
         hnmb_pkg::ST_FINISH: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = hnmb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hnmb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hnmb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Ring pointer and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else if (wr_en) begin
         wp_ff <= (wp_ff == hnmb_pkg::IDX_W'(hnmb_pkg::HIST_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         if (fill_ff != hnmb_pkg::CNT_W'(hnmb_pkg::HIST_DEPTH)) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   // Scan control.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff <= '0;
         bl_cnt_ff <= '0;
         rd_vld_ff <= 1'b0;
         d_vld_ff  <= 1'b0;
      end else begin
         if (accept) begin
            rd_cnt_ff <= '0;
            bl_cnt_ff <= '0;
         end else begin
            if (rd_issue) begin
               rd_cnt_ff <= rd_cnt_ff + 1'b1;
            end
            if (state_ff == hnmb_pkg::ST_BLEND) begin
               bl_cnt_ff <= bl_cnt_ff + 1'b1;
            end
         end
         rd_vld_ff <= rd_issue;
         d_vld_ff  <= rd_vld_ff;
      end
   end

   // Scan datapath: distance stage, then the running minimum. Strict less-than keeps the
   // lowest slot on equal distances.
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff <= {req_chan.energy_in, req_chan.risk_in, req_chan.reward_in};
      end
      rd_idx_ff <= rd_cnt_ff[hnmb_pkg::IDX_W-1:0];
      d_idx_ff  <= rd_idx_ff;
      dist_ff   <= dist_in;
      d_vec_ff  <= entry;
      if (d_vld_ff && (d_idx_ff == '0 || dist_ff < best_dist_ff)) begin
         best_dist_ff <= dist_ff;
         best_vec_ff  <= d_vec_ff;
         best_idx_ff  <= d_idx_ff;
      end
   end

   // Blend results come back one component at a time.
   always_ff @(posedge clock) begin
      if (bl_res.vld) begin
         case (bl_res.comp)
            hnmb_pkg::COMP_ENERGY: res_energy_ff <= bl_res.value;
            hnmb_pkg::COMP_RISK:   res_risk_ff   <= bl_res.value;
            default:               res_reward_ff <= bl_res.value;
         endcase
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (load_rsp) begin
         rsp_energy_ff <= res_energy_ff;
         rsp_risk_ff   <= res_risk_ff;
         rsp_reward_ff <= res_reward_ff;
         rsp_idx_ff    <= best_idx_ff;
      end
   end

   assign req_chan.ready       = (state_ff == hnmb_pkg::ST_IDLE);
   assign rsp_chan.valid       = rsp_vld_ff;
   assign rsp_chan.energy_out  = rsp_energy_ff;
   assign rsp_chan.risk_out    = rsp_risk_ff;
   assign rsp_chan.reward_out  = rsp_reward_ff;
   assign rsp_chan.match_index = rsp_idx_ff;

endmodule
